// ===== hdl/dit_pkg.sv =====
`default_nettype none

package dit_pkg;

	localparam int unsigned VAL_W  = 16;
	localparam int unsigned SLOT_W = 7;
	localparam int unsigned CNT_W  = 8;

	localparam logic [VAL_W-1:0] MARKER_RESET = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_DONE   = 3'b100
	} state_t;

	// search token as it moves down the row of cells
	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] rem;
	} token_t;

	// what a cell reports when the token ends its walk there
	typedef struct packed {
		logic stop;
		logic found;
	} cell_stat_t;

endpackage

`default_nettype wire

// ===== hdl/dit_item_if.sv =====
`default_nettype none

interface dit_item_if;
	logic                       valid;
	logic                       ready;
	logic                       start_table;
	logic [dit_pkg::VAL_W-1:0]  value;

	modport source (output valid, output start_table, output value, input ready);
	modport sink   (input valid, input start_table, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/dit_result_if.sv =====
`default_nettype none

interface dit_result_if;
	logic                        valid;
	logic                        ready;
	logic [dit_pkg::SLOT_W-1:0]  slot_index;
	logic                        is_new;
	logic [dit_pkg::CNT_W-1:0]   entries_in_use;
	logic                        overflow;

	modport source (output valid, output slot_index, output is_new, output entries_in_use,
		output overflow, input ready);
	modport sink   (input valid, input slot_index, input is_new, input entries_in_use,
		input overflow, output ready);
endinterface

`default_nettype wire

// ===== hdl/dit_cell.sv =====
`default_nettype none

module dit_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned IDX_W = 6
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dit_pkg::token_t           tok_in,
	output dit_pkg::token_t                tok_out,
	output dit_pkg::cell_stat_t            stat,
	input  wire logic [dit_pkg::VAL_W-1:0] marker,
	input  wire logic [dit_pkg::VAL_W-1:0] key,
	input  wire logic                      wr_en,
	input  wire logic [IDX_W-1:0]          wr_idx
);

	dit_pkg::token_t           tok_q;
	logic [dit_pkg::VAL_W-1:0] value_q;
	logic                      is_end;
	logic                      is_mark;
	logic                      is_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == IDX_W'(IDX))) begin
			value_q <= key;
		end
	end

	always_comb begin
		// slot at or beyond the count ends the walk before the stored value is looked at
		is_end  = (tok_q.rem == '0);
		is_mark = (value_q == marker);
		is_hit  = (value_q == key);
		stat.stop    = tok_q.vld & (is_end | is_mark | is_hit);
		stat.found   = tok_q.vld & ~is_end & ~is_mark & is_hit;
		tok_out.vld  = tok_q.vld & ~(is_end | is_mark | is_hit);
		tok_out.rem  = tok_q.rem - 1'b1;
	end

endmodule

`default_nettype wire

// ===== hdl/dedup_index_table_top.sv =====
// first-occurrence deduplication table
// item channel carries start_table and a 16-bit value; result channel gives
// slot_index, is_new, entries_in_use and overflow, one result per item
// cfg_we/cfg_wdata set the empty-slot marker; write only while idle
// each stored slot lives in one cell of a row; a search token enters cell 0
// after the transfer and moves one cell per cycle until it meets the marker,
// the value, the end of the filled slots, or falls off the last cell (full)
// an item that ends its walk at slot k has its result loaded into the result
// register once the walk has ended and that register is free; the next item is
// taken once the result is loaded, so one item is in flight at a time
// a new value is written into its cell in the cycle the walk ends
// a result waiting on a stalled receiver holds the following item in a wait
// state; the walk itself is never stopped
// arst_n empties the table (count zero) and sets the marker to 16'hFFFF;
// stored slot contents are not cleared and need not be
`default_nettype none

module dedup_index_table_top #(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	dit_item_if.sink                       item,
	dit_result_if.source                   result,
	input  wire logic                      cfg_we,
	input  wire logic [dit_pkg::VAL_W-1:0] cfg_wdata
);

	localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
	localparam int unsigned CNT_W  = dit_pkg::CNT_W;
	localparam int unsigned SLOT_W = dit_pkg::SLOT_W;

	dit_pkg::state_t           state_q;
	logic [dit_pkg::VAL_W-1:0] marker_q;
	logic [CNT_W-1:0]          count_q;
	logic [dit_pkg::VAL_W-1:0] key_q;
	logic [IDX_W-1:0]          pos_q;

	logic [SLOT_W-1:0]         res_slot_q;
	logic                      res_new_q;
	logic                      res_ovf_q;

	logic                      out_vld_q;
	logic [SLOT_W-1:0]         out_slot_q;
	logic                      out_new_q;
	logic [CNT_W-1:0]          out_cnt_q;
	logic                      out_ovf_q;

	dit_pkg::token_t           tok [MAX_ENTRIES+1];
	dit_pkg::cell_stat_t       stat [MAX_ENTRIES];

	logic                      accept;
	logic                      stop_any;
	logic                      found_any;
	logic                      done;
	logic                      wr_en;
	logic                      out_free;

	assign accept   = item.valid & item.ready;
	assign out_free = ~out_vld_q | result.ready;
	assign item.ready = (state_q == dit_pkg::ST_IDLE);

	assign tok[0].vld = accept;
	assign tok[0].rem = item.start_table ? '0 : count_q;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
			dit_cell #(
				.IDX   (gi),
				.IDX_W (IDX_W)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (tok[gi]),
				.tok_out (tok[gi+1]),
				.stat    (stat[gi]),
				.marker  (marker_q),
				.key     (key_q),
				.wr_en   (wr_en),
				.wr_idx  (pos_q)
			);
		end
	endgenerate

	always_comb begin
		stop_any  = 1'b0;
		found_any = 1'b0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			stop_any  = stop_any | stat[i].stop;
			found_any = found_any | stat[i].found;
		end
		// token leaving the last cell means every slot is taken
		done  = (state_q == dit_pkg::ST_SEARCH) & (stop_any | tok[MAX_ENTRIES].vld);
		wr_en = (state_q == dit_pkg::ST_SEARCH) & stop_any & ~found_any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dit_pkg::ST_IDLE;
			marker_q  <= dit_pkg::MARKER_RESET;
			count_q   <= '0;
			pos_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				marker_q <= cfg_wdata;
			end
			if ((state_q == dit_pkg::ST_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				dit_pkg::ST_IDLE: begin
					if (accept) begin
						pos_q   <= '0;
						state_q <= dit_pkg::ST_SEARCH;
						if (item.start_table) begin
							count_q <= '0;
						end
					end
				end
				dit_pkg::ST_SEARCH: begin
					if (done) begin
						state_q <= dit_pkg::ST_DONE;
						if (wr_en && (CNT_W'(pos_q) == count_q)) begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						pos_q <= IDX_W'(pos_q + 1'b1);
					end
				end
				dit_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= dit_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= dit_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= item.value;
		end
		if (done) begin
			if (stop_any) begin
				res_slot_q <= SLOT_W'(pos_q);
				res_new_q  <= ~found_any;
				res_ovf_q  <= 1'b0;
			end else begin
				res_slot_q <= '0;
				res_new_q  <= 1'b0;
				res_ovf_q  <= 1'b1;
			end
		end
		if ((state_q == dit_pkg::ST_DONE) && out_free) begin
			out_slot_q <= res_slot_q;
			out_new_q  <= res_new_q;
			out_ovf_q  <= res_ovf_q;
			out_cnt_q  <= count_q;
		end
	end

	assign result.valid          = out_vld_q;
	assign result.slot_index     = out_slot_q;
	assign result.is_new         = out_new_q;
	assign result.entries_in_use = out_cnt_q;
	assign result.overflow       = out_ovf_q;

endmodule

`default_nettype wire

// ===== hdl/dit_checker.sv =====
`default_nettype none

module dit_checker #(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       item_valid,
	input wire logic                       item_ready,
	input wire logic                       result_valid,
	input wire logic                       result_ready,
	input wire logic [dit_pkg::SLOT_W-1:0] slot_index,
	input wire logic                       is_new,
	input wire logic [dit_pkg::CNT_W-1:0]  entries_in_use,
	input wire logic                       overflow
);

	localparam int unsigned CNT_W = dit_pkg::CNT_W;

	// a stalled result keeps its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(slot_index) && $stable(is_new)
			&& $stable(entries_in_use) && $stable(overflow))
		else $error("stalled result changed");

	// one item at a time: no transfer right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is in flight");

	a_ovf_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && overflow |->
			!is_new && (slot_index == '0) && (entries_in_use == CNT_W'(MAX_ENTRIES)))
		else $error("overflow result with bad fields");

	// a reported slot always lies among the filled ones
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !overflow |->
			(CNT_W'(slot_index) < entries_in_use) && (entries_in_use <= CNT_W'(MAX_ENTRIES)))
		else $error("slot index outside the filled slots");

endmodule

bind dedup_index_table_top dit_checker #(
	.MAX_ENTRIES (MAX_ENTRIES)
) u_dit_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.slot_index     (result.slot_index),
	.is_new         (result.is_new),
	.entries_in_use (result.entries_in_use),
	.overflow       (result.overflow)
);

`default_nettype wire
